// ===== hdl/glla_pkg.sv =====
// Package for the Gaussian log-likelihood accumulator.
// Holds the item and result types, the fixed constants and the log table function.
// No dependencies.
package glla_pkg;

	// One input item.
	typedef struct packed {
		logic signed [31:0] observation;
		logic [31:0]        uncertainty;
		logic signed [31:0] prediction;
		logic [31:0]        model_variance;
		logic               last_item;
	} in_item_t;

	// One result item.
	typedef struct packed {
		logic signed [47:0] log_likelihood;
		logic [31:0]        item_count;
		logic               error_flag;
	} out_item_t;

	// Back-end sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_TBL,
		ST_MUL,
		ST_ACC
	} back_state_t;

	// ln(2) and 0.5*ln(2*pi) in Q32.
	localparam logic [63:0] LN2_Q32        = 64'd2977044472;
	localparam logic [63:0] HALF_LN2PI_Q32 = 64'd3946810947;

	// Saturation limits of the 48-bit sum.
	localparam logic signed [63:0] SUM_MAX = 64'sd140737488355327;
	localparam logic signed [63:0] SUM_MIN = -64'sd140737488355328;

	// Fractional log2 of (1 + idx / 2^tbits), fbits digits, by repeated squaring in Q30.
	// Only called with constant arguments to build a table.
	function automatic logic [31:0] rom_frac(input int idx, input int tbits, input int fbits);
		logic [63:0] m;
		logic [31:0] r;
		m = (64'd1 << 30) + (64'(idx) << (30 - tbits));
		r = '0;
		for (int k = 0; k < fbits; k++) begin
			m = (m * m) >> 30;
			r = r << 1;
			if (m >= (64'd1 << 31)) begin
				r = r | 32'd1;
				m = m >> 1;
			end
		end
		return r;
	endfunction

endpackage

// ===== hdl/gaussian_log_likelihood_accumulator.sv =====
// Top level of the Gaussian log-likelihood accumulator.
// Depends on glla_pkg, glla_front, glla_queue and glla_back.
//
//   channel   handshake          payload
//   input     push / full        item   (in_item_t)
//   result    empty / pop        result (out_item_t)
//
// Each item passes the front end and the queue, then the back end in order:
// a load step, the one-bit-per-cycle divider, table, multiply and sum.
// A zero total variance skips the divider, table and multiply and goes straight to the sum.
// The two-entry queue lets the front keep accepting while the back works or a result waits.
// Reset clears all control state and the running sum, count and error flag.
module gaussian_log_likelihood_accumulator import glla_pkg::*; #(
	parameter int FRAC_BITS = 16,
	parameter int LOG_TABLE_BITS = 8
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	output logic      full,
	input  in_item_t  item,
	output logic      empty,
	input  logic      pop,
	output out_item_t result
);

	localparam int VW = 65 - FRAC_BITS;
	localparam int QW = VW + 65 + 1;

	logic          ent_v;
	logic          ent_rdy;
	logic [VW-1:0] ent_var;
	logic [64:0]   ent_sq;
	logic          ent_last;
	logic          q_v;
	logic          q_pop;
	logic [QW-1:0] q_data;

	glla_front #(.FRAC_BITS(FRAC_BITS), .VW(VW)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.item     (item),
		.ent_v    (ent_v),
		.ent_rdy  (ent_rdy),
		.ent_var  (ent_var),
		.ent_sq   (ent_sq),
		.ent_last (ent_last)
	);

	glla_queue #(.W(QW)) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_v    (ent_v),
		.wr_rdy  (ent_rdy),
		.wr_data ({ent_var, ent_sq, ent_last}),
		.rd_v    (q_v),
		.rd_pop  (q_pop),
		.rd_data (q_data)
	);

	glla_back #(
		.FRAC_BITS      (FRAC_BITS),
		.LOG_TABLE_BITS (LOG_TABLE_BITS),
		.VW             (VW)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q_v    (q_v),
		.q_pop  (q_pop),
		.q_var  (q_data[QW-1 -: VW]),
		.q_sq   (q_data[65:1]),
		.q_last (q_data[0]),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

endmodule

// ===== hdl/glla_front.sv =====
// Front end of the accumulator: accepts items and forms the total variance and squared residual.
// Depends on glla_pkg.
module glla_front import glla_pkg::*; #(
	parameter int FRAC_BITS = 16,
	parameter int VW = 65 - FRAC_BITS
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	output logic           full,
	input  in_item_t       item,
	output logic           ent_v,
	input  logic           ent_rdy,
	output logic [VW-1:0]  ent_var,
	output logic [64:0]    ent_sq,
	output logic           ent_last
);

	in_item_t    item_s1;
	logic        v_s1;
	logic [63:0] usq_s2;
	logic [64:0] dsq_s2;
	logic [31:0] mvar_s2;
	logic        last_s2;
	logic        v_s2;
	logic        adv2;
	logic        accept;
	logic signed [32:0] diff;
	logic [32:0] adiff;

	// Stage flow control.
	assign adv2   = !v_s2 || ent_rdy;
	assign full   = v_s1 && !adv2;
	assign accept = push && !full;

	// Stage 1 holds the raw item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (adv2) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item;
		end
	end

	// Residual magnitude.
	always_comb begin
		diff  = 33'(item_s1.observation) - 33'(item_s1.prediction);
		adiff = diff[32] ? 33'(-diff) : 33'(diff);
	end

	// Stage 2 holds the two products, the model variance and the last flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv2 && v_s1) begin
			usq_s2  <= 64'(item_s1.uncertainty) * 64'(item_s1.uncertainty);
			dsq_s2  <= 65'(adiff) * 65'(adiff);
			mvar_s2 <= item_s1.model_variance;
			last_s2 <= item_s1.last_item;
		end
	end

	// Total variance, squared residual and last flag toward the queue.
	assign ent_v    = v_s2;
	assign ent_var  = VW'(mvar_s2) + VW'(usq_s2 >> FRAC_BITS);
	assign ent_sq   = dsq_s2;
	assign ent_last = last_s2;

endmodule

// ===== hdl/glla_queue.sv =====
// Two-entry queue between the front and back ends of the accumulator.
// Depends on glla_pkg.
module glla_queue import glla_pkg::*; #(
	parameter int W = 115
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr_v,
	output logic         wr_rdy,
	input  logic [W-1:0] wr_data,
	output logic         rd_v,
	input  logic         rd_pop,
	output logic [W-1:0] rd_data
);

	logic [W-1:0] mem_q [2];
	logic         wp_q;
	logic         rp_q;
	logic [1:0]   cnt_q;
	logic         do_wr;
	logic         do_rd;

	assign wr_rdy  = (cnt_q != 2'd2);
	assign rd_v    = (cnt_q != 2'd0);
	assign do_wr   = wr_v && wr_rdy;
	assign do_rd   = rd_pop && rd_v;
	assign rd_data = mem_q[rp_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_wr) begin
				wp_q <= !wp_q;
			end
			if (do_rd) begin
				rp_q <= !rp_q;
			end
			cnt_q <= cnt_q + 2'(do_wr) - 2'(do_rd);
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wp_q] <= wr_data;
		end
	end

endmodule

// ===== hdl/glla_back.sv =====
// Back end of the accumulator: serial divider, log table, multiply and saturating sum.
// Depends on glla_pkg.
module glla_back import glla_pkg::*; #(
	parameter int FRAC_BITS = 16,
	parameter int LOG_TABLE_BITS = 8,
	parameter int VW = 65 - FRAC_BITS
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_v,
	output logic          q_pop,
	input  logic [VW-1:0] q_var,
	input  logic [64:0]   q_sq,
	input  logic          q_last,
	output logic          empty,
	input  logic          pop,
	output out_item_t     result
);

	localparam int DW   = 65;
	localparam int CW   = $clog2(DW);
	localparam int MW   = $clog2(VW);
	localparam int TS   = 1 << LOG_TABLE_BITS;
	localparam int LW   = 8 + FRAC_BITS;
	localparam int PW   = LW + FRAC_BITS + 2;
	localparam logic [63:0] LN2F  = (LN2_Q32 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);
	localparam logic [63:0] HALFC =
		(HALF_LN2PI_Q32 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);
	localparam logic [50:0] HQ_MAX = 51'd1 << 50;

	back_state_t state_q, state_nx;

	logic [FRAC_BITS-1:0] log_rom [TS];
	logic [VW-1:0]    var_q;
	logic [VW-1:0]    rem_q;
	logic [DW-1:0]    dq_q;
	logic [CW-1:0]    cnt_q;
	logic [VW-1:0]    norm_q;
	logic [MW-1:0]    msb_q;
	logic             last_q;
	logic             zv_q;
	logic signed [LW-1:0] l2_q;
	logic [50:0]      hq_q;
	logic signed [PW-1:0] prod_q;
	logic signed [47:0] sum_q;
	logic [31:0]      count_q;
	logic             err_q;
	out_item_t        out_q;
	logic             out_v_q;

	logic [VW:0]      trial;
	logic             ge;
	logic [DW-2:0]    qhalf;
	logic [LOG_TABLE_BITS-1:0] idx;
	logic signed [7:0] msbmf;
	logic signed [63:0] halfln;
	logic signed [63:0] sum_w;
	logic signed [47:0] sum_sat;
	logic             sat;
	logic [31:0]      count_inc;
	logic             acc_go;
	logic             load;

	// Constant log table.
	for (genvar g = 0; g < TS; g++) begin : g_rom
		assign log_rom[g] = FRAC_BITS'(rom_frac(g, LOG_TABLE_BITS, FRAC_BITS));
	end

	// Next state.
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (q_v) begin
					state_nx = (q_var == '0) ? ST_ACC : ST_DIV;
				end
			end
			ST_DIV: begin
				if (cnt_q == '0) begin
					state_nx = ST_TBL;
				end
			end
			ST_TBL:  state_nx = ST_MUL;
			ST_MUL:  state_nx = ST_ACC;
			ST_ACC: begin
				if (acc_go) begin
					state_nx = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		load  = 1'b0;
		q_pop = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				load  = q_v;
				q_pop = q_v;
			end
			default: begin
				load  = 1'b0;
				q_pop = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// One quotient bit per cycle, with the leading-one search alongside.
	assign trial = {rem_q, dq_q[DW-1]};
	assign ge    = (trial >= {1'b0, var_q});

	always_ff @(posedge clk) begin
		if (load) begin
			var_q  <= q_var;
			rem_q  <= '0;
			dq_q   <= q_sq;
			cnt_q  <= CW'(DW - 1);
			norm_q <= q_var;
			msb_q  <= MW'(VW - 1);
			last_q <= q_last;
			zv_q   <= (q_var == '0);
		end else if (state_q == ST_DIV) begin
			rem_q <= ge ? VW'(trial - {1'b0, var_q}) : VW'(trial);
			dq_q  <= {dq_q[DW-2:0], ge};
			cnt_q <= cnt_q - CW'(1);
			if (!norm_q[VW-1]) begin
				norm_q <= norm_q << 1;
				msb_q  <= msb_q - MW'(1);
			end
		end
	end

	// Table lookup, clamped half quotient and the product with ln(2).
	assign idx   = norm_q[VW-2 -: LOG_TABLE_BITS];
	assign msbmf = 8'(msb_q) - 8'(FRAC_BITS);
	assign qhalf = dq_q[DW-1:1];

	always_ff @(posedge clk) begin
		if (state_q == ST_TBL) begin
			l2_q <= {msbmf, log_rom[idx]};
			hq_q <= (qhalf > (DW-1)'(HQ_MAX)) ? HQ_MAX : 51'(qhalf);
		end
		if (state_q == ST_MUL) begin
			prod_q <= PW'(l2_q) * signed'(PW'(LN2F));
		end
	end

	// Term and saturating sum.
	always_comb begin
		halfln  = 64'(prod_q >>> (FRAC_BITS + 1));
		sum_w   = 64'(sum_q) - signed'(HALFC) - halfln - signed'(64'(hq_q));
		sat     = 1'b0;
		sum_sat = 48'(sum_w);
		if (zv_q) begin
			sat     = 1'b1;
			sum_sat = 48'(SUM_MIN);
		end else if (sum_w > SUM_MAX) begin
			sat     = 1'b1;
			sum_sat = 48'(SUM_MAX);
		end else if (sum_w < SUM_MIN) begin
			sat     = 1'b1;
			sum_sat = 48'(SUM_MIN);
		end
		count_inc = (count_q == '1) ? count_q : count_q + 32'd1;
		acc_go    = (state_q == ST_ACC) && (!last_q || !out_v_q || pop);
	end

	// Running state and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			count_q <= '0;
			err_q   <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (pop && out_v_q) begin
				out_v_q <= 1'b0;
			end
			if (acc_go) begin
				if (last_q) begin
					out_v_q <= 1'b1;
					sum_q   <= '0;
					count_q <= '0;
					err_q   <= 1'b0;
				end else begin
					sum_q   <= sum_sat;
					count_q <= count_inc;
					err_q   <= err_q || sat;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc_go && last_q) begin
			out_q.log_likelihood <= sum_sat;
			out_q.item_count     <= count_inc;
			out_q.error_flag     <= err_q || sat;
		end
	end

	assign empty  = !out_v_q;
	assign result = out_q;

	// The divider always hands over to the table step after its last bit.
	a_div_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && cnt_q == '0) |=> (state_q == ST_TBL))
		else $error("divider did not hand over to table step");

	// A waiting result is neither lost nor changed.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && !pop) |=> (out_v_q && $stable(out_q)))
		else $error("waiting result changed");

	// The queue is only drained between items.
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> (state_q == ST_IDLE))
		else $error("queue read while busy");

endmodule
